[hw/rtl/tlb_pkg.sv]
package tlb_pkg;

    // Bar geometry
    localparam int NUM_PIXELS = 16;
    localparam int PIX_W      = (NUM_PIXELS > 1) ? $clog2(NUM_PIXELS) : 1;
    localparam int CNT_W      = 5;

    // Field widths
    localparam int PERIOD_W = 16;
    localparam int LIGHT_W  = 10;
    localparam int CHAN_W   = 8;
    localparam int PROD_W   = LIGHT_W + CHAN_W;

    // Divider: quotient below NUM_PIXELS needs PIX_W steps
    localparam int DIV_W  = PERIOD_W + PIX_W;
    localparam int STEP_W = (PIX_W > 1) ? $clog2(PIX_W) : 1;
    localparam int SAT_W  = PERIOD_W + $clog2(NUM_PIXELS + 1);

    // Full-scale light reading
    localparam logic [LIGHT_W:0] LIGHT_FULL = (LIGHT_W + 1)'(1023);

    // Configuration port
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;
    localparam logic [CFG_IDX_W-1:0] REG_RATE_NUM  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_LIGHT_THR = 1'b1;
    localparam logic [PERIOD_W-1:0]  RATE_NUM_RESET  = 16'd9375;
    localparam logic [LIGHT_W-1:0]   LIGHT_THR_RESET = 10'd102;

    // Job queue between front and back
    localparam int JOB_DEPTH = 2;
    localparam int JQ_PTR_W  = (JOB_DEPTH > 1) ? $clog2(JOB_DEPTH) : 1;
    localparam int JQ_CNT_W  = $clog2(JOB_DEPTH + 1);

    typedef struct packed {
        logic [PERIOD_W-1:0] period;
        logic [LIGHT_W-1:0]  light;
    } sample_t;

    typedef struct packed {
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] blue;
        logic              last_pixel;
    } pixel_t;

    typedef struct packed {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
    } color_t;

    typedef struct packed {
        logic [CNT_W-1:0] count;
        color_t           color;
    } job_t;

    // Full-brightness colors: green at low speed, red at high speed
    function automatic color_t color_rom(input logic [3:0] idx);
        color_t c;
        unique case (idx)
            4'd0:    c = '{red: 8'd0,   green: 8'd255, blue: 8'd0};
            4'd1:    c = '{red: 8'd10,  green: 8'd245, blue: 8'd0};
            4'd2:    c = '{red: 8'd20,  green: 8'd235, blue: 8'd0};
            4'd3:    c = '{red: 8'd30,  green: 8'd225, blue: 8'd0};
            4'd4:    c = '{red: 8'd50,  green: 8'd205, blue: 8'd0};
            4'd5:    c = '{red: 8'd60,  green: 8'd195, blue: 8'd0};
            4'd6:    c = '{red: 8'd100, green: 8'd155, blue: 8'd0};
            4'd7:    c = '{red: 8'd160, green: 8'd95,  blue: 8'd0};
            4'd8:    c = '{red: 8'd190, green: 8'd65,  blue: 8'd0};
            4'd9:    c = '{red: 8'd210, green: 8'd45,  blue: 8'd0};
            4'd10:   c = '{red: 8'd225, green: 8'd30,  blue: 8'd0};
            4'd11:   c = '{red: 8'd235, green: 8'd20,  blue: 8'd0};
            4'd12:   c = '{red: 8'd245, green: 8'd10,  blue: 8'd0};
            default: c = '{red: 8'd255, green: 8'd0,   blue: 8'd0};
        endcase
        return c;
    endfunction

    // floor(x / 1023) for x <= 1023 * 255: x = q0*1024 + lo = q0*1023 + (lo + q0),
    // and lo + q0 stays below 2*1023, so one compare fixes it up.
    function automatic logic [CHAN_W-1:0] div_full(input logic [PROD_W-1:0] x);
        logic [CHAN_W-1:0] q0;
        logic [LIGHT_W:0]  r;
        q0 = x[PROD_W-1:LIGHT_W];
        r  = {1'b0, x[LIGHT_W-1:0]} + (LIGHT_W + 1)'(q0);
        return (r >= LIGHT_FULL) ? q0 + CHAN_W'(1) : q0;
    endfunction

endpackage

[hw/rtl/tachometer_led_bar_driver.sv]
// Tachometer LED bar driver. Each sample pushed in carries a rotation period in
// timer ticks and a light reading; the bar length is rate_numerator / period
// (0 for a stopped rotor, capped at 16). When that length differs from the one
// last drawn, or the light moved by more than light_threshold, the block emits
// a full redraw of 16 pixels (GRB, first pixel first, last_pixel marking the
// end); otherwise the sample produces nothing. Lit pixels share one color from
// a green-to-red table, scaled by light / 1023; unlit pixels are black.
// Timing: the front end is busy (full high) while it works on a sample; on a
// stopped or saturated rotor it skips the one-bit-per-cycle quotient loop. A
// redraw holds it in a further state to hand the job over, longer while the job
// queue is full.
// A two-entry job queue sits between the front end and the pixel streamer,
// which first loads a job and then sends one pixel per cycle while pop keeps
// up; it loads the next job only after the last pixel of the current one.
// Configuration writes (index 0: rate_numerator, index 1: light_threshold)
// must only be made while no item is in flight.
module tachometer_led_bar_driver (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_we,
    input  logic [tlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlb_pkg::CFG_DATA_W-1:0] cfg_data,
    // sample queue side
    input  logic                          push,
    input  tlb_pkg::sample_t              sample,
    output logic                          full,
    // pixel queue side
    output logic                          empty,
    output tlb_pkg::pixel_t               pixel,
    input  logic                          pop
);

    // front end -> job queue
    logic          q_push;
    logic          q_full;
    tlb_pkg::job_t q_wr_job;

    // job queue -> pixel streamer
    logic          q_pop;
    logic          q_empty;
    tlb_pkg::job_t q_rd_job;

    // Front end: config registers, divider, redraw decision, color scaling
    tlb_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .push      (push),
        .sample    (sample),
        .full      (full),
        .job_push  (q_push),
        .job       (q_wr_job),
        .job_full  (q_full)
    );

    // Short queue of redraw jobs so either side can stall alone
    tlb_job_fifo u_job_fifo (
        .clk     (clk),
        .rst_n   (rst_n),
        .wr_en   (q_push),
        .wr_job  (q_wr_job),
        .q_full  (q_full),
        .rd_en   (q_pop),
        .rd_job  (q_rd_job),
        .q_empty (q_empty)
    );

    // Back end: expands one job into the pixel stream
    tlb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_empty (q_empty),
        .job       (q_rd_job),
        .job_pop   (q_pop),
        .empty     (empty),
        .pixel     (pixel),
        .pop       (pop)
    );

    // No job is written into a full queue
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("job queue overflow");

    // No job is taken from an empty queue
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("job queue underflow");

    // Every color in the table has no blue, so no pixel may carry any
    a_blue_zero: assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (pixel.blue == '0))
        else $error("pixel with nonzero blue");

    // The front end works on one sample at a time
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (push && !full) |=> full)
        else $error("front end not busy after accepting an item");

endmodule

[hw/rtl/tlb_front.sv]
module tlb_front (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [tlb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [tlb_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                          push,
    input  tlb_pkg::sample_t              sample,
    output logic                          full,
    output logic                          job_push,
    output tlb_pkg::job_t                 job,
    input  logic                          job_full
);

    typedef enum logic [3:0] {
        F_IDLE = 4'b0001,
        F_DIV  = 4'b0010,
        F_MUL  = 4'b0100,
        F_PUSH = 4'b1000
    } front_state_t;

    front_state_t state_reg, state_next;

    logic [tlb_pkg::PERIOD_W-1:0] rate_num_reg;
    logic [tlb_pkg::LIGHT_W-1:0]  light_thr_reg;
    logic [tlb_pkg::CNT_W-1:0]    shown_count_reg, shown_count_next;
    logic [tlb_pkg::LIGHT_W-1:0]  shown_light_reg, shown_light_next;
    logic [tlb_pkg::STEP_W-1:0]   step_reg, step_next;

    logic [tlb_pkg::PERIOD_W-1:0] rem_reg, rem_next;
    logic [tlb_pkg::DIV_W-1:0]    div_reg, div_next;
    logic [tlb_pkg::CNT_W-1:0]    count_reg, count_next;
    logic [tlb_pkg::LIGHT_W-1:0]  light_reg, light_next;
    logic [tlb_pkg::PROD_W-1:0]   prod_g_reg, prod_g_next;
    logic [tlb_pkg::PROD_W-1:0]   prod_r_reg, prod_r_next;
    logic [tlb_pkg::PROD_W-1:0]   prod_b_reg, prod_b_next;

    logic [tlb_pkg::SAT_W-1:0]    sat_limit;
    logic                         sat;
    logic                         bit_fits;
    logic [tlb_pkg::LIGHT_W-1:0]  light_diff;
    logic                         refresh;
    logic [tlb_pkg::CNT_W-1:0]    rom_idx;
    tlb_pkg::color_t              rom_color;

    assign full = (state_reg != F_IDLE);

    // count saturates once numerator >= NUM_PIXELS * period
    assign sat_limit = tlb_pkg::SAT_W'(sample.period) * tlb_pkg::SAT_W'(tlb_pkg::NUM_PIXELS);
    assign sat       = (tlb_pkg::SAT_W'(rate_num_reg) >= sat_limit);
    assign bit_fits  = (tlb_pkg::DIV_W'(rem_reg) >= div_reg);

    assign light_diff = (light_reg >= shown_light_reg) ? light_reg - shown_light_reg
                                                       : shown_light_reg - light_reg;
    assign refresh    = (count_reg != shown_count_reg) || (light_diff > light_thr_reg);
    assign rom_idx    = count_reg - tlb_pkg::CNT_W'(1);
    assign rom_color  = tlb_pkg::color_rom(rom_idx[3:0]);

    always_comb
    begin
        state_next       = state_reg;
        shown_count_next = shown_count_reg;
        shown_light_next = shown_light_reg;
        step_next        = step_reg;
        rem_next         = rem_reg;
        div_next         = div_reg;
        count_next       = count_reg;
        light_next       = light_reg;
        prod_g_next      = prod_g_reg;
        prod_r_next      = prod_r_reg;
        prod_b_next      = prod_b_reg;
        job_push         = 1'b0;
        job.count        = count_reg;
        job.color.red    = tlb_pkg::div_full(prod_r_reg);
        job.color.green  = tlb_pkg::div_full(prod_g_reg);
        job.color.blue   = tlb_pkg::div_full(prod_b_reg);

        unique case (state_reg)
            F_IDLE:
            begin
                if (push)
                begin
                    light_next = sample.light;
                    rem_next   = rate_num_reg;
                    div_next   = tlb_pkg::DIV_W'(sample.period) << (tlb_pkg::PIX_W - 1);
                    step_next  = tlb_pkg::STEP_W'(tlb_pkg::PIX_W - 1);
                    count_next = '0;
                    if (sample.period == '0)
                    begin
                        state_next = F_MUL;
                    end
                    else if (sat)
                    begin
                        count_next = tlb_pkg::CNT_W'(tlb_pkg::NUM_PIXELS);
                        state_next = F_MUL;
                    end
                    else
                    begin
                        state_next = F_DIV;
                    end
                end
            end
            F_DIV:
            begin
                // restoring division, one quotient bit a cycle
                if (bit_fits)
                begin
                    rem_next = rem_reg - div_reg[tlb_pkg::PERIOD_W-1:0];
                end
                count_next = {count_reg[tlb_pkg::CNT_W-2:0], bit_fits};
                div_next   = div_reg >> 1;
                step_next  = step_reg - tlb_pkg::STEP_W'(1);
                if (step_reg == '0)
                begin
                    state_next = F_MUL;
                end
            end
            F_MUL:
            begin
                prod_r_next = tlb_pkg::PROD_W'(light_reg) * tlb_pkg::PROD_W'(rom_color.red);
                prod_g_next = tlb_pkg::PROD_W'(light_reg) * tlb_pkg::PROD_W'(rom_color.green);
                prod_b_next = tlb_pkg::PROD_W'(light_reg) * tlb_pkg::PROD_W'(rom_color.blue);
                if (refresh)
                begin
                    shown_count_next = count_reg;
                    shown_light_next = light_reg;
                    state_next       = F_PUSH;
                end
                else
                begin
                    state_next = F_IDLE;
                end
            end
            F_PUSH:
            begin
                if (!job_full)
                begin
                    job_push   = 1'b1;
                    state_next = F_IDLE;
                end
            end
            default:
            begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= F_IDLE;
            rate_num_reg    <= tlb_pkg::RATE_NUM_RESET;
            light_thr_reg   <= tlb_pkg::LIGHT_THR_RESET;
            shown_count_reg <= '0;
            shown_light_reg <= '0;
            step_reg        <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            shown_count_reg <= shown_count_next;
            shown_light_reg <= shown_light_next;
            step_reg        <= step_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    tlb_pkg::REG_RATE_NUM:  rate_num_reg  <= cfg_data;
                    tlb_pkg::REG_LIGHT_THR: light_thr_reg <= cfg_data[tlb_pkg::LIGHT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg    <= rem_next;
        div_reg    <= div_next;
        count_reg  <= count_next;
        light_reg  <= light_next;
        prod_g_reg <= prod_g_next;
        prod_r_reg <= prod_r_next;
        prod_b_reg <= prod_b_next;
    end

endmodule

[hw/rtl/tlb_job_fifo.sv]
module tlb_job_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          wr_en,
    input  tlb_pkg::job_t wr_job,
    output logic          q_full,
    input  logic          rd_en,
    output tlb_pkg::job_t rd_job,
    output logic          q_empty
);

    tlb_pkg::job_t                 mem [tlb_pkg::JOB_DEPTH];
    logic [tlb_pkg::JQ_PTR_W-1:0]  wr_ptr_reg, rd_ptr_reg;
    logic [tlb_pkg::JQ_CNT_W-1:0]  fill_reg;

    assign q_full  = (fill_reg == tlb_pkg::JQ_CNT_W'(tlb_pkg::JOB_DEPTH));
    assign q_empty = (fill_reg == '0);
    assign rd_job  = mem[rd_ptr_reg];

    function automatic logic [tlb_pkg::JQ_PTR_W-1:0] ptr_inc(
        input logic [tlb_pkg::JQ_PTR_W-1:0] p);
        return (p == tlb_pkg::JQ_PTR_W'(tlb_pkg::JOB_DEPTH - 1)) ? '0
                                                                 : p + tlb_pkg::JQ_PTR_W'(1);
    endfunction

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_ptr_reg] <= wr_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (wr_en)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (rd_en)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (wr_en && !rd_en)
            begin
                fill_reg <= fill_reg + tlb_pkg::JQ_CNT_W'(1);
            end
            else if (rd_en && !wr_en)
            begin
                fill_reg <= fill_reg - tlb_pkg::JQ_CNT_W'(1);
            end
        end
    end

endmodule

[hw/rtl/tlb_back.sv]
module tlb_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            job_empty,
    input  tlb_pkg::job_t   job,
    output logic            job_pop,
    output logic            empty,
    output tlb_pkg::pixel_t pixel,
    input  logic            pop
);

    logic                      active_reg, active_next;
    logic [tlb_pkg::PIX_W-1:0] pix_reg, pix_next;
    logic                      out_valid_reg, out_valid_next;
    tlb_pkg::job_t             cur_reg, cur_next;
    tlb_pkg::pixel_t           out_reg, out_next;

    logic                      slot_free;
    logic                      lit;
    logic                      at_last;

    assign slot_free = !out_valid_reg || pop;
    assign job_pop   = !active_reg && !job_empty;
    assign lit       = (tlb_pkg::CNT_W'(pix_reg) < cur_reg.count);
    assign at_last   = (pix_reg == tlb_pkg::PIX_W'(tlb_pkg::NUM_PIXELS - 1));

    assign empty = !out_valid_reg;
    assign pixel = out_reg;

    always_comb
    begin
        active_next    = active_reg;
        pix_next       = pix_reg;
        out_valid_next = out_valid_reg;
        cur_next       = cur_reg;
        out_next       = out_reg;

        if (pop)
        begin
            out_valid_next = 1'b0;
        end

        if (job_pop)
        begin
            active_next = 1'b1;
            pix_next    = '0;
            cur_next    = job;
        end
        else if (active_reg && slot_free)
        begin
            out_valid_next      = 1'b1;
            out_next.green      = lit ? cur_reg.color.green : '0;
            out_next.red        = lit ? cur_reg.color.red   : '0;
            out_next.blue       = lit ? cur_reg.color.blue  : '0;
            out_next.last_pixel = at_last;
            if (at_last)
            begin
                active_next = 1'b0;
                pix_next    = '0;
            end
            else
            begin
                pix_next = pix_reg + tlb_pkg::PIX_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            pix_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            active_reg    <= active_next;
            pix_reg       <= pix_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
        out_reg <= out_next;
    end

endmodule
